@@ rtl/cbpe_pkg.sv @@
// Shared constants for the cubic Bezier point evaluator.
`timescale 1ns / 1ps

package cbpe_pkg;

   // Configuration register file: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y
   localparam int NUM_REGS  = 8;
   localparam int CSR_IDX_W = 3;

   // Curve geometry
   localparam int NUM_AXES  = 2;
   localparam int NUM_PTS   = 4;

   // Pipeline depth, accept to result
   localparam int NUM_STAGES = 8;

endpackage

@@ rtl/cubic_bezier_point_eval.sv @@
// Top level: pipelined cubic Bezier point evaluator with bilinear coverage weights.
// ------------------------------------------------------------------------------
// Usage: write the four control points (integer pixels) through the csr_ port;
// index 0..7 selects p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y. Writes take
// effect at the clock edge where csr_wr_en is high and must land while no item
// is in flight. Indexes past the list are ignored.
// Each req_ transfer carries one curve parameter t in Q1.FRAC_BITS (values above
// 1.0 saturate). Each rsp_ transfer returns the curve point split into integer
// pixel and fraction, plus the four bilinear weights of the 2x2 neighborhood.
// Throughput: one item per cycle while the receiver does not stall; the eight
// register stages are the input register, the three de Casteljau levels
// (a multiply stage and an add stage each) and the coverage multiply stage.
// Back-pressure: each stage holds only while the stage after it is full and
// stalled, so bubbles close up behind a stalled receiver; nothing is dropped
// or repeated. Reset (synchronous) clears the control points to zero and
// empties the pipeline.
// ------------------------------------------------------------------------------
`timescale 1ns / 1ps

module cubic_bezier_point_eval #(
   parameter int FRAC_BITS  = 10,
   parameter int COORD_BITS = 10,
   localparam int TW        = FRAC_BITS + 1,
   localparam int REQ_W     = ((TW + 7) / 8) * 8,
   localparam int RSP_BITS  = 2 * COORD_BITS + 2 * FRAC_BITS + 4 * TW,
   localparam int RSP_W     = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // configuration write port
   input  logic                          csr_wr_en,
   input  logic [cbpe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_BITS-1:0]         csr_wdata,
   // parameter stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,  // param_t, zero padded
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pixel_x, pixel_y, frac_x, frac_y, cover_top_left, cover_top_right,
   // cover_bottom_left, cover_bottom_right, zero padded
   output logic [RSP_W-1:0]              rsp_tdata
);

   localparam int NA  = cbpe_pkg::NUM_AXES;
   localparam int NP  = cbpe_pkg::NUM_PTS;
   localparam int NS  = cbpe_pkg::NUM_STAGES;
   localparam int VW  = COORD_BITS + FRAC_BITS;   // fixed-point coordinate
   localparam int DW  = VW + 1;                   // signed difference
   localparam int PW  = DW + TW + 1;              // signed product
   localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

   // (b - a) * t, exact
   function automatic logic signed [PW-1:0] diff_mul(input logic [VW-1:0] a,
                                                     input logic [VW-1:0] b,
                                                     input logic [TW-1:0] t);
      logic signed [DW-1:0]   d;
      logic signed [TW:0]     ts;
      logic signed [PW-1:0]   p;
      d  = $signed({1'b0, b}) - $signed({1'b0, a});
      ts = $signed({1'b0, t});
      p  = d * ts;
      return p;
   endfunction

   // a + floor(p / 2^FRAC_BITS); the result stays between the two end points
   function automatic logic [VW-1:0] lerp_add(input logic [VW-1:0] a,
                                              input logic signed [PW-1:0] p);
      logic signed [PW-1:0] s;
      s = $signed({{(PW - VW){1'b0}}, a}) + (p >>> FRAC_BITS);
      return s[VW-1:0];
   endfunction

   // ---------------- configuration registers
   logic [COORD_BITS-1:0] cfg_ff [cbpe_pkg::NUM_REGS];
   logic [VW-1:0]         cp_fx  [NA][NP];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cbpe_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_wr_en && (int'(csr_index) < cbpe_pkg::NUM_REGS)) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // control points as fixed-point values, x and y interleaved in the register file
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int j = 0; j < NP; j++) begin
            cp_fx[a][j] = {cfg_ff[2 * j + a], {FRAC_BITS{1'b0}}};
         end
      end
   end

   // ---------------- stage flow control
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;
   logic [NS:0]   adv;

   // a stage loads when empty or when the stage after it moves
   always_comb begin
      adv[NS] = rsp_tready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k + 1];
      end
      vld_in = vld_ff;
      for (int k = 0; k < NS; k++) begin
         if (adv[k]) begin
            vld_in[k] = (k == 0) ? req_tvalid : vld_ff[(k == 0) ? 0 : k - 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NS-1];

   // ---------------- datapath registers
   logic [TW-1:0]          t0_ff, t1_ff, t2_ff, t3_ff, t4_ff;
   logic [TW-1:0]          t0_in;
   logic signed [PW-1:0]   prod1_ff [NA][3];
   logic signed [PW-1:0]   prod1_in [NA][3];
   logic [VW-1:0]          lv1_ff   [NA][3];
   logic [VW-1:0]          lv1_in   [NA][3];
   logic signed [PW-1:0]   prod2_ff [NA][2];
   logic signed [PW-1:0]   prod2_in [NA][2];
   logic [VW-1:0]          base3_ff [NA][2];
   logic [VW-1:0]          lv2_ff   [NA][2];
   logic [VW-1:0]          lv2_in   [NA][2];
   logic signed [PW-1:0]   prod3_ff [NA];
   logic signed [PW-1:0]   prod3_in [NA];
   logic [VW-1:0]          base5_ff [NA];
   logic [VW-1:0]          pt_ff    [NA];
   logic [VW-1:0]          pt_in    [NA];
   logic [COORD_BITS-1:0]  pix_ff   [NA];
   logic [FRAC_BITS-1:0]   frac_ff  [NA];
   logic [TW-1:0]          cov_ff   [4];
   logic [TW-1:0]          cov_in   [4];
   logic [TW-1:0]          req_t;
   logic [FRAC_BITS-1:0]   fx, fy;
   logic [TW-1:0]          gx, gy;
   logic [2*TW-1:0]        cprod    [4];

   // saturate the parameter at 1.0
   assign req_t = req_tdata[TW-1:0];
   assign t0_in = (req_t > ONE) ? ONE : req_t;

   // level products and sums
   always_comb begin
      for (int a = 0; a < NA; a++) begin
         for (int j = 0; j < 3; j++) begin
            prod1_in[a][j] = diff_mul(cp_fx[a][j], cp_fx[a][j + 1], t0_ff);
            lv1_in[a][j]   = lerp_add(cp_fx[a][j], prod1_ff[a][j]);
         end
         for (int j = 0; j < 2; j++) begin
            prod2_in[a][j] = diff_mul(lv1_ff[a][j], lv1_ff[a][j + 1], t2_ff);
            lv2_in[a][j]   = lerp_add(base3_ff[a][j], prod2_ff[a][j]);
         end
         prod3_in[a] = diff_mul(lv2_ff[a][0], lv2_ff[a][1], t4_ff);
         pt_in[a]    = lerp_add(base5_ff[a], prod3_ff[a]);
      end
   end

   // split the point and form the bilinear weights
   always_comb begin
      fx = pt_ff[0][FRAC_BITS-1:0];
      fy = pt_ff[1][FRAC_BITS-1:0];
      gx = ONE - TW'(fx);
      gy = ONE - TW'(fy);
      cprod[0] = gx * gy;
      cprod[1] = TW'(fx) * gy;
      cprod[2] = gx * TW'(fy);
      cprod[3] = TW'(fx) * TW'(fy);
      for (int i = 0; i < 4; i++) begin
         cov_in[i] = cprod[i][FRAC_BITS +: TW];
      end
   end

   // advance each stage on its own enable
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         t0_ff <= t0_in;
      end
      if (adv[1]) begin
         prod1_ff <= prod1_in;
         t1_ff    <= t0_ff;
      end
      if (adv[2]) begin
         lv1_ff <= lv1_in;
         t2_ff  <= t1_ff;
      end
      if (adv[3]) begin
         prod2_ff <= prod2_in;
         t3_ff    <= t2_ff;
         for (int a = 0; a < NA; a++) begin
            base3_ff[a][0] <= lv1_ff[a][0];
            base3_ff[a][1] <= lv1_ff[a][1];
         end
      end
      if (adv[4]) begin
         lv2_ff <= lv2_in;
         t4_ff  <= t3_ff;
      end
      if (adv[5]) begin
         prod3_ff <= prod3_in;
         for (int a = 0; a < NA; a++) begin
            base5_ff[a] <= lv2_ff[a][0];
         end
      end
      if (adv[6]) begin
         pt_ff <= pt_in;
      end
      if (adv[7]) begin
         cov_ff <= cov_in;
         for (int a = 0; a < NA; a++) begin
            pix_ff[a]  <= pt_ff[a][FRAC_BITS +: COORD_BITS];
            frac_ff[a] <= pt_ff[a][FRAC_BITS-1:0];
         end
      end
   end

   // pack the result, lowest field first
   assign rsp_tdata = RSP_W'({cov_ff[3], cov_ff[2], cov_ff[1], cov_ff[0],
                              frac_ff[1], frac_ff[0], pix_ff[1], pix_ff[0]});

endmodule

@@ dv/tb_cubic_bezier_point_eval.sv @@
// Testbench for the cubic Bezier point evaluator: directed and random curves, checked per field.
`timescale 1ns / 1ps

module tb_cubic_bezier_point_eval;

   localparam int FRAC_BITS  = 10;
   localparam int COORD_BITS = 10;
   localparam int TW         = FRAC_BITS + 1;
   localparam int REQ_W      = ((TW + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 * COORD_BITS + 2 * FRAC_BITS + 4 * TW;
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8;
   localparam int NUM_FIELDS = 8;

   localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
   localparam longint FRAC_MASK  = ONE_Q - 1;
   localparam longint COORD_MASK = (longint'(1) << COORD_BITS) - 1;
   localparam int T_MAX          = (1 << TW) - 1;
   localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

   // bit offsets of the result fields inside rsp_tdata, lowest first
   localparam int OFS_PY  = COORD_BITS;
   localparam int OFS_FX  = 2 * COORD_BITS;
   localparam int OFS_FY  = 2 * COORD_BITS + FRAC_BITS;
   localparam int OFS_CV  = 2 * COORD_BITS + 2 * FRAC_BITS;

   localparam int LONG_HOLD     = 100;
   localparam int DRAIN_CYCLES  = cbpe_pkg::NUM_STAGES + 8;
   localparam longint TIMEOUT_NS = 2_000_000;

   typedef enum logic [cbpe_pkg::CSR_IDX_W-1:0] {
      REG_P0_X, REG_P0_Y, REG_P1_X, REG_P1_Y, REG_P2_X, REG_P2_Y, REG_P3_X, REG_P3_Y
   } point_reg_type;

   typedef enum int { AXIS_X = 0, AXIS_Y = 1 } axis_type;

   // pixel_x, pixel_y, frac_x, frac_y, top_left, top_right, bottom_left, bottom_right
   typedef logic [NUM_FIELDS-1:0][TW-1:0] point_fields_type;
   typedef logic [cbpe_pkg::NUM_REGS-1:0][COORD_BITS-1:0] curve_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [cbpe_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [COORD_BITS-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;      // param_t, zero padded
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // pixel_x, pixel_y, frac_x, frac_y, cover_top_left, cover_top_right,
   // cover_bottom_left, cover_bottom_right, zero padded
   logic [RSP_W-1:0] rsp_tdata;

   // shadow copy of the control point registers
   logic [COORD_BITS-1:0] ctrl_pts [cbpe_pkg::NUM_REGS] = '{default: '0};
   point_fields_type expected_points [$];
   string field_names [NUM_FIELDS] = '{"pixel_x", "pixel_y", "frac_x", "frac_y",
      "cover_top_left", "cover_top_right", "cover_bottom_left", "cover_bottom_right"};

   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;
   bit sender_steady = 1'b0;
   int unsigned hold_requests = 0;
   int unsigned holds_served = 0;
   int unsigned hold_left = 0;
   int unsigned rx_cycle = 0;

   cubic_bezier_point_eval #(
      .FRAC_BITS (FRAC_BITS),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // one lerp step: a + floor((b - a) * t / 2^FRAC_BITS)
   function automatic longint lerp_q(longint a, longint b, longint t);
      return a + (((b - a) * t) >>> FRAC_BITS);
   endfunction

   // three de Casteljau levels on one axis, control points taken from the shadow
   function automatic longint bezier_axis(axis_type axis, longint t);
      longint c [4];
      longint a0, a1, a2, b0, b1;
      for (int k = 0; k < 4; k++) begin
         c[k] = longint'(ctrl_pts[2 * k + int'(axis)]) <<< FRAC_BITS;
      end
      a0 = lerp_q(c[0], c[1], t);
      a1 = lerp_q(c[1], c[2], t);
      a2 = lerp_q(c[2], c[3], t);
      b0 = lerp_q(a0, a1, t);
      b1 = lerp_q(a1, a2, t);
      return lerp_q(b0, b1, t);
   endfunction

   function automatic point_fields_type predict_point(logic [TW-1:0] t_raw);
      longint t, px, py, fx, fy, gx, gy;
      point_fields_type r;
      // saturate t above 1.0
      t = (longint'(t_raw) > ONE_Q) ? ONE_Q : longint'(t_raw);
      px = bezier_axis(AXIS_X, t);
      py = bezier_axis(AXIS_Y, t);
      if (px < 0) px = 0;
      if (py < 0) py = 0;
      fx = px & FRAC_MASK;
      fy = py & FRAC_MASK;
      gx = ONE_Q - fx;
      gy = ONE_Q - fy;
      r[0] = TW'((px >>> FRAC_BITS) & COORD_MASK);
      r[1] = TW'((py >>> FRAC_BITS) & COORD_MASK);
      r[2] = TW'(fx);
      r[3] = TW'(fy);
      r[4] = TW'((gx * gy) >>> FRAC_BITS);
      r[5] = TW'((fx * gy) >>> FRAC_BITS);
      r[6] = TW'((gx * fy) >>> FRAC_BITS);
      r[7] = TW'((fx * fy) >>> FRAC_BITS);
      return r;
   endfunction

   // ------------------------------------------------------------ result check

   task automatic report_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // compare every result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      point_fields_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got[0] = TW'(rsp_tdata[COORD_BITS-1:0]);
         got[1] = TW'(rsp_tdata[OFS_PY +: COORD_BITS]);
         got[2] = TW'(rsp_tdata[OFS_FX +: FRAC_BITS]);
         got[3] = TW'(rsp_tdata[OFS_FY +: FRAC_BITS]);
         for (int k = 0; k < 4; k++) got[4 + k] = rsp_tdata[OFS_CV + k * TW +: TW];
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected result, pixel_x", -1, got[0]);
         end else begin
            want = expected_points.pop_front();
            for (int f = 0; f < NUM_FIELDS; f++) begin
               if (got[f] !== want[f]) report_mismatch(field_names[f], want[f], got[f]);
            end
         end
      end
   end

   // --------------------------------------------------------------- receiver

   // stall pattern cycles through modes; a requested long hold takes priority
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_cycle[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= rx_cycle[0];
         endcase
      end
   end

   // ----------------------------------------------------------------- sender

   // all driver tasks start and end just after a falling edge
   task automatic send_param(logic [TW-1:0] t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_steady ? 0 : $urandom_range(0, 6);
         repeat (gap) @(negedge clock);
      end
      burst_left--;
      req_tdata = '0;
      req_tdata[TW-1:0] = t;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_points.insert(expected_points.size(), predict_point(t));
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   function automatic logic [TW-1:0] random_param();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: return '0;
               1: return TW'(1);
               2: return TW'(ONE_Q - 1);
               default: return TW'(ONE_Q);
            endcase
         end
         1: return TW'($urandom_range(int'(ONE_Q) + 1, T_MAX));
         default: return TW'($urandom_range(0, int'(ONE_Q)));
      endcase
   endfunction

   // wait until every transfer in flight has come back
   task automatic wait_idle();
      while (expected_points.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic write_point_reg(point_reg_type idx, logic [COORD_BITS-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      ctrl_pts[idx] = value;
   endtask

   task automatic load_curve(curve_type curve);
      wait_idle();
      for (int i = 0; i < cbpe_pkg::NUM_REGS; i++)
         write_point_reg(point_reg_type'(i), curve[i]);
   endtask

   // ------------------------------------------------------------------ tests

   // points cleared by reset: every t lands on the origin
   task automatic test_reset_points();
      send_param('0);
      send_param(TW'(ONE_Q));
      send_param(TW'(T_MAX));
   endtask

   // pixel at the right and bottom edge, then a zigzag curve with fractions
   task automatic test_corner_params();
      curve_type zigzag;
      load_curve({cbpe_pkg::NUM_REGS{COORD_BITS'(COORD_MAX)}});
      send_param('0);
      send_param(TW'(ONE_Q / 2));
      send_param(TW'(ONE_Q));
      send_param(TW'(T_MAX));
      for (int i = 0; i < cbpe_pkg::NUM_REGS; i++)
         zigzag[i] = ((i / 2 + i % 2) % 2 == 0) ? '0 : COORD_BITS'(COORD_MAX);
      load_curve(zigzag);
      send_param(TW'(1));
      send_param(TW'(3));
      send_param(TW'(341));
      send_param(TW'(683));
      send_param(TW'(ONE_Q - 1));
      send_param(TW'(ONE_Q));
      send_param(TW'(ONE_Q + 1));
      send_param(TW'(ONE_Q + ONE_Q / 2));
   endtask

   // new control points per phase, extremes first, then random t values
   task automatic test_random_curves(int phases, int items_per_phase);
      curve_type curve;
      for (int p = 0; p < phases; p++) begin
         for (int i = 0; i < cbpe_pkg::NUM_REGS; i++) begin
            case ($urandom_range(0, 4))
               0: curve[i] = '0;
               1: curve[i] = COORD_BITS'(COORD_MAX);
               default: curve[i] = COORD_BITS'($urandom_range(0, COORD_MAX));
            endcase
         end
         if (p == 0) curve = '0;
         if (p == 1) curve = {cbpe_pkg::NUM_REGS{COORD_BITS'(COORD_MAX)}};
         load_curve(curve);
         sender_steady = (p % 3 == 2);
         for (int n = 0; n < items_per_phase; n++) send_param(random_param());
      end
      sender_steady = 1'b0;
   endtask

   // hold the receiver off while items keep coming, so the input stalls
   task automatic test_output_stall(int count);
      sender_steady = 1'b1;
      hold_requests++;
      for (int n = 0; n < count; n++) send_param(random_param());
      sender_steady = 1'b0;
   endtask

   // ------------------------------------------------------------------- main

   initial begin
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_points();
      test_corner_params();
      test_random_curves(8, 110);
      test_output_stall(60);
      test_random_curves(2, 50);

      while (expected_points.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // bound the run in case the pipeline hangs
   initial begin
      #(TIMEOUT_NS);
      $display("TB_ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/cbpe_pkg.sv
rtl/cubic_bezier_point_eval.sv
dv/tb_cubic_bezier_point_eval.sv
